// ----- hdl/tcsa_pkg.sv -----
// Shared types, constants and codes for the two-region slot allocator.
package tcsa_pkg;

  localparam int SLOT_COUNT   = 128;
  localparam int REGION_SPLIT = 64;

  // Fixed field widths of the request and result.
  localparam int START_W = 7;
  localparam int CNT_W   = 8;

  localparam int SLOT_W   = $clog2(SLOT_COUNT);
  localparam int IDX_W    = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int DOWN_TOP = (REGION_SPLIT < SLOT_COUNT) ? REGION_SPLIT : SLOT_COUNT;
  localparam bit UP_EMPTY = (REGION_SPLIT >= SLOT_COUNT);

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_FREE    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_FIXED      = 2'd0,
    MODE_HIGH_FIRST = 2'd1,
    MODE_LOW_FIRST  = 2'd2,
    MODE_INVALID    = 2'd3
  } mode_t;

  typedef struct packed {
    op_t                operation;
    mode_t              mode;
    logic [START_W-1:0] start_slot;
    logic [CNT_W-1:0]   slot_count;
  } in_req_t;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] first_slot;
  } out_res_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SET_FIX,
    DP_SET_DOWN,
    DP_SET_UP,
    DP_INC,
    DP_DEC,
    DP_FOUND_FIX,
    DP_FOUND_DOWN,
    DP_FOUND_UP,
    DP_MARK,
    DP_CLEAR
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_FAIL,
    RES_FREE
  } res_t;

  typedef struct packed {
    dp_op_t op;
    res_t   res;
  } dp_cmd_t;

  typedef struct packed {
    op_t   op;
    mode_t mode;
    logic  cnt_zero;
    logic  fix_over;
    logic  cur_used;
    logic  run_hit;
    logic  left_one;
    logic  at_bottom;
    logic  at_top;
  } dp_stat_t;

endpackage

// ----- hdl/tcsa_dp.sv -----
// Datapath: slot bitmap, scan index, run and count registers, result register.
module tcsa_dp import tcsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  input  in_req_t  in_data,
  output dp_stat_t stat,
  output out_res_t res_data
);

  logic                  map_mem [SLOT_COUNT];
  logic                  rd_bit_r;
  in_req_t               req_r, req_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  logic [CNT_W-1:0]      run_r, run_nxt;
  logic [IDX_W-1:0]      got_r, got_nxt;
  out_res_t              res_r, res_nxt;
  logic                  map_we;
  logic                  map_wbit;
  logic                  cur_used;
  logic [CNT_W-1:0]      run_step;
  logic [SUM_W-1:0]      up_start;
  logic [SUM_W-1:0]      fix_end;

  // rd_bit_r always holds the bit at idx_r: it is read at idx_nxt, and a write
  // always moves the index on, so read and write never hit the same slot.
  assign cur_used = rd_bit_r;
  assign run_step = cur_used ? '0 : run_r + CNT_W'(1);
  assign up_start = SUM_W'(idx_r) + SUM_W'(1) - SUM_W'(req_r.slot_count);
  assign fix_end  = SUM_W'(req_r.start_slot) + SUM_W'(req_r.slot_count);

  always_comb begin
    stat.op        = req_r.operation;
    stat.mode      = req_r.mode;
    stat.cnt_zero  = (req_r.slot_count == '0);
    stat.fix_over  = (fix_end > SUM_W'(SLOT_COUNT));
    stat.cur_used  = cur_used;
    stat.run_hit   = !cur_used && (SUM_W'(run_r) + SUM_W'(1) >= SUM_W'(req_r.slot_count));
    stat.left_one  = (left_r == CNT_W'(1));
    stat.at_bottom = (idx_r == '0);
    stat.at_top    = (idx_r == IDX_W'(SLOT_COUNT - 1));
  end

  always_comb begin
    req_nxt  = req_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    run_nxt  = run_r;
    got_nxt  = got_r;
    map_we   = 1'b0;
    map_wbit = 1'b0;
    case (cmd.op)
      DP_CAPTURE: req_nxt = in_data;
      DP_SET_FIX: begin
        idx_nxt  = IDX_W'(req_r.start_slot);
        left_nxt = req_r.slot_count;
        run_nxt  = '0;
      end
      DP_SET_DOWN: begin
        idx_nxt = IDX_W'(DOWN_TOP - 1);
        run_nxt = '0;
      end
      DP_SET_UP: begin
        idx_nxt = IDX_W'(REGION_SPLIT);
        run_nxt = '0;
      end
      DP_INC: begin
        idx_nxt  = idx_r + IDX_W'(1);
        left_nxt = left_r - CNT_W'(1);
        run_nxt  = run_step;
      end
      DP_DEC: begin
        idx_nxt = idx_r - IDX_W'(1);
        run_nxt = run_step;
      end
      DP_FOUND_FIX: begin
        got_nxt  = IDX_W'(req_r.start_slot);
        idx_nxt  = IDX_W'(req_r.start_slot);
        left_nxt = req_r.slot_count;
      end
      DP_FOUND_DOWN: begin
        got_nxt  = idx_r;
        left_nxt = req_r.slot_count;
      end
      DP_FOUND_UP: begin
        got_nxt  = up_start[IDX_W-1:0];
        idx_nxt  = up_start[IDX_W-1:0];
        left_nxt = req_r.slot_count;
      end
      DP_MARK: begin
        map_we   = 1'b1;
        map_wbit = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        left_nxt = left_r - CNT_W'(1);
      end
      DP_CLEAR: begin
        map_we   = 1'b1;
        map_wbit = 1'b0;
        idx_nxt  = idx_r + IDX_W'(1);
        left_nxt = left_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    case (cmd.res)
      RES_OK: begin
        res_nxt.granted    = 1'b1;
        res_nxt.first_slot = got_r[START_W-1:0];
      end
      RES_FAIL: begin
        res_nxt.granted    = 1'b0;
        res_nxt.first_slot = '0;
      end
      RES_FREE: begin
        res_nxt.granted    = 1'b1;
        res_nxt.first_slot = req_r.start_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[idx_r[SLOT_W-1:0]] <= map_wbit;
    end
    rd_bit_r <= map_mem[idx_nxt[SLOT_W-1:0]];
  end

  // start the clearing pass at slot 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    left_r <= left_nxt;
    run_r  <= run_nxt;
    got_r  <= got_nxt;
    res_r  <= res_nxt;
  end

  assign res_data = res_r;

endmodule

// ----- hdl/tcsa_ctrl.sv -----
// Controller: sequences capture, scans, fallback, marking and clearing.
module tcsa_ctrl import tcsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_FIX,
    S_DOWN,
    S_UP,
    S_MARK,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   fb_r, fb_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign out_busy  = out_valid_r && !out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    fb_nxt    = fb_r;
    cmd.op    = DP_NOP;
    cmd.res   = RES_NONE;
    case (state_r)
      S_INIT: begin
        // clear one slot per cycle until the last one
        cmd.op = DP_CLEAR;
        if (stat.at_top) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the previous result has been taken
        if (!out_busy) begin
          if (stat.op == OP_FREE) begin
            if (stat.cnt_zero) begin
              cmd.res   = RES_FREE;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = DP_SET_FIX;
              state_nxt = S_CLEAR;
            end
          end else begin
            case (stat.mode)
              MODE_FIXED: begin
                if (stat.cnt_zero || stat.fix_over) begin
                  cmd.res   = RES_FAIL;
                  state_nxt = S_IDLE;
                end else begin
                  cmd.op    = DP_SET_FIX;
                  state_nxt = S_FIX;
                end
              end
              MODE_HIGH_FIRST: begin
                if (stat.cnt_zero) begin
                  cmd.res   = RES_FAIL;
                  state_nxt = S_IDLE;
                end else begin
                  cmd.op    = DP_SET_DOWN;
                  fb_nxt    = 1'b0;
                  state_nxt = S_DOWN;
                end
              end
              MODE_LOW_FIRST: begin
                if (stat.cnt_zero) begin
                  cmd.res   = RES_FAIL;
                  state_nxt = S_IDLE;
                end else if (UP_EMPTY) begin
                  cmd.op    = DP_SET_DOWN;
                  fb_nxt    = 1'b1;
                  state_nxt = S_DOWN;
                end else begin
                  cmd.op    = DP_SET_UP;
                  fb_nxt    = 1'b0;
                  state_nxt = S_UP;
                end
              end
              default: begin
                cmd.res   = RES_FAIL;
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_FIX: begin
        if (stat.cur_used) begin
          cmd.res   = RES_FAIL;
          state_nxt = S_IDLE;
        end else if (stat.left_one) begin
          cmd.op    = DP_FOUND_FIX;
          state_nxt = S_MARK;
        end else begin
          cmd.op = DP_INC;
        end
      end
      S_DOWN: begin
        if (stat.run_hit) begin
          cmd.op    = DP_FOUND_DOWN;
          state_nxt = S_MARK;
        end else if (stat.at_bottom) begin
          // fall back to the high region once
          if (!fb_r && !UP_EMPTY) begin
            cmd.op    = DP_SET_UP;
            fb_nxt    = 1'b1;
            state_nxt = S_UP;
          end else begin
            cmd.res   = RES_FAIL;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = DP_DEC;
        end
      end
      S_UP: begin
        if (stat.run_hit) begin
          cmd.op    = DP_FOUND_UP;
          state_nxt = S_MARK;
        end else if (stat.at_top) begin
          if (!fb_r) begin
            cmd.op    = DP_SET_DOWN;
            fb_nxt    = 1'b1;
            state_nxt = S_DOWN;
          end else begin
            cmd.res   = RES_FAIL;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = DP_INC;
        end
      end
      S_MARK: begin
        cmd.op = DP_MARK;
        if (stat.left_one) begin
          cmd.res   = RES_OK;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        // stop at the last slot even if count remains
        if (stat.left_one || stat.at_top) begin
          cmd.res   = RES_FREE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res != RES_NONE) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      fb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/two_region_contiguous_slot_allocator_top.sv -----
// Top level of the two-region contiguous slot allocator.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_ready    in_data   (in_req_t)
//   result    out        out_valid / out_ready  out_data  (out_res_t)
//
// One request at a time: accept, decode, then one bitmap slot per cycle.
// A search visits up to 128 slots over both regions; a grant then marks
// slot_count slots and a free clears up to slot_count slots of the bitmap.
// After reset a clearing pass frees one slot per cycle; in_ready stays low
// until all 128 slots are clear. A new request is taken while a result
// waits; its decode stalls until that result is taken.
module two_region_contiguous_slot_allocator_top import tcsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcsa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .res_data (out_data)
  );

endmodule
